/* rtl/tmrf_pkg.sv */
// Package for the trimmed mean range filter: widths, register map, reset values,
// configuration and controller/datapath handshake structs. No dependencies.
package tmrf_pkg;

  localparam int MAX_WINDOW = 8;

  localparam int SAMPLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int RANGE_W  = 20;
  localparam int COUNT_W  = 4;
  localparam int FRAC_W   = 4;
  localparam int WSIZE_W  = 4;
  localparam int TRIM_W   = 2;

  localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
  localparam int KEY_W    = SAMPLE_W + 1;
  localparam int SUM_W    = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int DIVD_W   = ((SUM_W + FRAC_W + 1) / 2) * 2;
  localparam int DIV_STEPS = DIVD_W / 2;
  localparam int STEPS_MAX = (MAX_WINDOW > DIV_STEPS) ? MAX_WINDOW : DIV_STEPS;
  localparam int STEP_W   = (STEPS_MAX > 1) ? $clog2(STEPS_MAX) : 1;

  localparam logic [STEP_W-1:0] LAST_SORT = STEP_W'(MAX_WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_SUM  = STEP_W'(MAX_WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_DIV  = STEP_W'(DIV_STEPS - 1);

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLOSE = 2'd1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_MIN_RANGE    = 2'd0;
  localparam logic [1:0] REG_CLOSE_AS_MIN = 2'd1;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;
  localparam logic [1:0] REG_TRIM_COUNT   = 2'd3;

  localparam logic [SAMPLE_W-1:0] MIN_RANGE_RST    = 16'd20;
  localparam logic                CLOSE_AS_MIN_RST = 1'b1;
  localparam logic [WSIZE_W-1:0]  WINDOW_SIZE_RST  = 4'd5;
  localparam logic [TRIM_W-1:0]   TRIM_COUNT_RST   = 2'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] near_mm;
    logic                close_as_min;
    logic [WSIZE_W-1:0]  window_size;
    logic [TRIM_W-1:0]   trim_count;
  } cfg_t;

  typedef struct packed {
    logic              update;
    logic              prep;
    logic              sort;
    logic              sum;
    logic              div_init;
    logic              div;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic out_free;
  } sts_t;

endpackage

/* rtl/tmrf_if.sv */
// Valid/ready channel interfaces for reading words and result words.
// Depends on tmrf_pkg.
interface tmrf_in_if;
  import tmrf_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SAMPLE_W-1:0] distance_mm;
  modport source (output valid, status, distance_mm, input ready);
  modport sink (input valid, status, distance_mm, output ready);
endinterface

interface tmrf_out_if;
  import tmrf_pkg::*;
  logic               valid;
  logic               ready;
  logic               range_valid;
  logic [RANGE_W-1:0] filtered_range;
  logic [COUNT_W-1:0] sample_count;
  modport source (output valid, range_valid, filtered_range, sample_count, input ready);
  modport sink (input valid, range_valid, filtered_range, sample_count, output ready);
endinterface

/* rtl/tmrf_ctrl.sv */
// Sequencer for the filter: accepts a word, then steps the datapath through prepare, sort,
// sum and divide passes (only prepare for an empty window), loads the result. Depends on tmrf_pkg.
module tmrf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tmrf_pkg::sts_t sts,
  output tmrf_pkg::cmd_t cmd
);
  import tmrf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_SORT = 7'b0000100,
    ST_SUM  = 7'b0001000,
    ST_DIVI = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.update = 1'b1;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = sts.empty ? ST_FIN : ST_SORT;
      end
      ST_SORT: begin
        cmd.sort = 1'b1;
        if (step_r == LAST_SORT) begin
          step_nxt  = '0;
          state_nxt = ST_SUM;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (step_r == LAST_SUM) begin
          step_nxt  = '0;
          state_nxt = ST_DIVI;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (step_r == LAST_DIV) begin
          step_nxt  = '0;
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.update, cmd.prep, cmd.sort, cmd.sum, cmd.div_init, cmd.div, cmd.out_load}))
    else $error("more than one datapath command active");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in progress");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_ready)
    else $error("not idle after result load");
`endif

endmodule

/* rtl/tmrf_dp.sv */
// Datapath: sample window shift line, transposition sort, trimmed sum,
// radix-4 restoring divider and result register. Depends on tmrf_pkg.
module tmrf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmrf_pkg::cfg_t                cfg,
  input  logic [tmrf_pkg::STATUS_W-1:0] in_status,
  input  logic [tmrf_pkg::SAMPLE_W-1:0] in_distance_mm,
  input  tmrf_pkg::cmd_t                cmd,
  output tmrf_pkg::sts_t                sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_range_valid,
  output logic [tmrf_pkg::RANGE_W-1:0]  out_filtered_range,
  output logic [tmrf_pkg::COUNT_W-1:0]  out_sample_count
);
  import tmrf_pkg::*;

  logic [SAMPLE_W-1:0] win_r [MAX_WINDOW];
  logic [SAMPLE_W-1:0] win_nxt [MAX_WINDOW];
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [KEY_W-1:0]    sk_r [MAX_WINDOW];
  logic [KEY_W-1:0]    sk_nxt [MAX_WINDOW];
  logic [FILL_W-1:0]   trim_r, hi_r, cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [DIVD_W-1:0]   dv_r, dv_nxt;
  logic [FILL_W-1:0]   rem_r, rem_nxt;
  logic                out_valid_r, out_rv_r;
  logic [RANGE_W-1:0]  out_fr_r;
  logic [COUNT_W-1:0]  out_sc_r;

  logic [SAMPLE_W-1:0] sample;
  logic                keep;
  logic [FILL_W-1:0]   limit, grown;
  logic [FILL_W-1:0]   half, trim;
  logic [FILL_W-1:0]   idx;
  logic                take;

  // incoming reading and window update
  always_comb begin
    sample = '0;
    keep   = 1'b0;
    if (in_status == STATUS_OK) begin
      sample = in_distance_mm;
      keep   = 1'b1;
    end else if (in_status == STATUS_CLOSE && cfg.close_as_min) begin
      sample = cfg.near_mm;
      keep   = 1'b1;
    end
    keep = keep && (sample != '0);

    if (int'(cfg.window_size) > MAX_WINDOW) begin
      limit = FILL_W'(MAX_WINDOW);
    end else begin
      limit = FILL_W'(cfg.window_size);
    end
    grown = (fill_r >= FILL_W'(MAX_WINDOW)) ? fill_r : fill_r + 1'b1;

    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (cmd.update) begin
      if (keep) begin
        win_nxt[0] = sample;
        for (int k = 1; k < MAX_WINDOW; k++) begin
          win_nxt[k] = win_r[k-1];
        end
        fill_nxt = (grown > limit) ? limit : grown;
      end else begin
        fill_nxt = '0;
      end
    end
  end

  // trim bounds
  always_comb begin
    half = (fill_r - 1'b1) >> 1;
    trim = (FILL_W'(cfg.trim_count) > half) ? half : FILL_W'(cfg.trim_count);
    idx  = FILL_W'(cmd.step);
    take = (idx >= trim_r) && (idx < hi_r);
  end

  // sort keys: empty slots carry a high flag so they sort to the top
  always_comb begin
    sk_nxt = sk_r;
    if (cmd.prep) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        sk_nxt[k] = {(FILL_W'(k) >= fill_r), win_r[k]};
      end
    end else if (cmd.sort) begin
      for (int k = 0; k < MAX_WINDOW - 1; k++) begin
        if (k[0] == cmd.step[0] && sk_r[k] > sk_r[k+1]) begin
          sk_nxt[k]   = sk_r[k+1];
          sk_nxt[k+1] = sk_r[k];
        end
      end
    end else if (cmd.sum) begin
      for (int k = 0; k < MAX_WINDOW - 1; k++) begin
        sk_nxt[k] = sk_r[k+1];
      end
    end
  end

  // two restoring quotient bits per cycle during the divide pass
  always_comb begin
    logic [FILL_W:0] t;
    dv_nxt  = dv_r;
    rem_nxt = rem_r;
    for (int b = 0; b < 2; b++) begin
      t      = {rem_nxt, dv_nxt[DIVD_W-1]};
      dv_nxt = dv_nxt << 1;
      if (t >= {1'b0, cnt_r}) begin
        rem_nxt   = FILL_W'(t - {1'b0, cnt_r});
        dv_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[FILL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    sk_r  <= sk_nxt;
    if (cmd.prep) begin
      trim_r <= trim;
      hi_r   <= fill_r - trim;
      cnt_r  <= fill_r - (trim << 1);
      sum_r  <= '0;
    end
    if (cmd.sum && take) begin
      sum_r <= sum_r + SUM_W'(sk_r[0][SAMPLE_W-1:0]);
    end
    if (cmd.div_init) begin
      dv_r  <= DIVD_W'(sum_r) << FRAC_W;
      rem_r <= '0;
    end else if (cmd.div) begin
      dv_r  <= dv_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      if (fill_r == '0) begin
        out_rv_r <= 1'b0;
        out_fr_r <= '0;
        out_sc_r <= '0;
      end else begin
        out_rv_r <= 1'b1;
        out_fr_r <= dv_r[RANGE_W-1:0];
        out_sc_r <= COUNT_W'(fill_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.empty          = (fill_r == '0);
  assign sts.out_free       = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_range_valid    = out_rv_r;
  assign out_filtered_range = out_fr_r;
  assign out_sample_count   = out_sc_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_WINDOW))
    else $error("window fill beyond capacity");

  a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.prep && fill_r != '0) |=> (cnt_r != '0))
    else $error("zero divisor for nonempty window");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rv_r) |-> (out_sc_r != '0))
    else $error("valid range with empty sample count");
`endif

endmodule

/* rtl/trimmed_mean_range_filter_top.sv */
// Each reading word passes from acceptance to a loaded result through eight odd-even
// sort passes, a summing pass and a divider that yields two quotient bits per cycle;
// when the window ends up empty, it goes straight from prepare to the result load.
// The next reading is accepted as soon as the result sits in the output register.
// Depends on tmrf_pkg, tmrf_if, tmrf_ctrl and tmrf_dp.
module trimmed_mean_range_filter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  tmrf_in_if.sink                      in_ch,
  tmrf_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmrf_pkg::PADDR_W-1:0] paddr,
  input  logic [tmrf_pkg::PDATA_W-1:0] pwdata,
  output logic [tmrf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import tmrf_pkg::*;

  cfg_t       cfg_r;
  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_mm      <= MIN_RANGE_RST;
      cfg_r.close_as_min <= CLOSE_AS_MIN_RST;
      cfg_r.window_size  <= WINDOW_SIZE_RST;
      cfg_r.trim_count   <= TRIM_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_RANGE:    cfg_r.near_mm      <= pwdata[SAMPLE_W-1:0];
        REG_CLOSE_AS_MIN: cfg_r.close_as_min <= pwdata[0];
        REG_WINDOW_SIZE:  cfg_r.window_size  <= pwdata[WSIZE_W-1:0];
        REG_TRIM_COUNT:   cfg_r.trim_count   <= pwdata[TRIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_RANGE:    prdata = PDATA_W'(cfg_r.near_mm);
      REG_CLOSE_AS_MIN: prdata = PDATA_W'(cfg_r.close_as_min);
      REG_WINDOW_SIZE:  prdata = PDATA_W'(cfg_r.window_size);
      REG_TRIM_COUNT:   prdata = PDATA_W'(cfg_r.trim_count);
      default:          prdata = '0;
    endcase
  end

  tmrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmrf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_status          (in_ch.status),
    .in_distance_mm     (in_ch.distance_mm),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_range_valid    (out_ch.range_valid),
    .out_filtered_range (out_ch.filtered_range),
    .out_sample_count   (out_ch.sample_count)
  );

endmodule
